/* src/syscall_latency_profiler_core_assert.svh */
// ----------------------------------------------------------------------------
// Profiler assertion macros
// Shared concurrent assertion macros for the profiler RTL.
// ----------------------------------------------------------------------------
`ifndef SYSCALL_LATENCY_PROFILER_CORE_ASSERT_SVH
`define SYSCALL_LATENCY_PROFILER_CORE_ASSERT_SVH

// cond must never hold outside reset
`define SLP_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");

// ante implies cons in the same cycle
`define SLP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

/* src/slp_pkg.sv */
// ----------------------------------------------------------------------------
// Profiler package
// Codes, default sizes and shared types.
// ----------------------------------------------------------------------------
package slp_pkg;

	localparam int THREAD_SLOTS_DEF = 64;
	localparam int NUM_CALLS_DEF    = 512;

	localparam logic [1:0] FUNC_ENTER = 2'd0;
	localparam logic [1:0] FUNC_EXIT  = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_FILTERED = 3'd1;
	localparam logic [2:0] ST_BADCALL  = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOENTRY  = 3'd4;

	typedef struct packed {
		logic wr_hit;
		logic wr_free;
		logic clr_hit;
	} cell_ctl_t;

	typedef struct packed {
		logic [63:0] cnt;
		logic [63:0] orph;
		logic [63:0] busy;
	} stat_t;

endpackage

/* src/slp_cell.sv */
// ----------------------------------------------------------------------------
// Open-call cell
// One entry of the open-call table; passes the free-slot chain onward.
// ----------------------------------------------------------------------------
module slp_cell #(
	parameter int CW = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  slp_pkg::cell_ctl_t ctl,
	input  logic [21:0]       key,
	input  logic [CW-1:0]     call_in,
	input  logic [63:0]       time_in,
	input  logic              taken_in,
	output logic              taken_out,
	output logic              match,
	output logic [CW-1:0]     call_o,
	output logic [63:0]       start_o
);
	import slp_pkg::*;

	logic          valid_q;
	logic [21:0]   thread_q;
	logic [CW-1:0] call_q;
	logic [63:0]   start_q;
	logic          first_free;

	assign match      = valid_q && (thread_q == key);
	assign first_free = !valid_q && !taken_in;
	assign taken_out  = taken_in || !valid_q;
	assign call_o     = match ? call_q : '0;
	assign start_o    = match ? start_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.wr_free && first_free) begin
			valid_q <= 1'b1;
		end else if (ctl.clr_hit && match) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctl.wr_free && first_free) || (ctl.wr_hit && match)) begin
			thread_q <= key;
			call_q   <= call_in;
			start_q  <= time_in;
		end
	end

endmodule

/* src/syscall_latency_profiler_core.sv */
// ----------------------------------------------------------------------------
// Syscall latency profiler core
// Open-call table as a row of cells plus per-call counter memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_stall): func, thread_num, group_num,
//   call_number, time_ns. Result channel (out_valid/out_stall): status,
//   call_index, elapsed_ns, call_count, orphan_count, busy_sum.
//   Every request yields exactly one result.
//   The user must write group_filter over the APB port only while the block
//   is idle; the block itself does not enforce this. One request is in
//   flight at a time; it passes through LOOK, UPD, RD and RES before the
//   next is taken (counter memory read, write back, report read on one port).
//   Table lookup is a single pass over the cell row.
//   Reset: all table entries invalid, filter -1, then a clearing pass over
//   all NUM_CALLS entries zeroes the counter memory; in_stall is high meanwhile.
//   When the receiver stalls, the result holds in the output register and
//   the next request may still be processed up to its report stage.
// ----------------------------------------------------------------------------
module syscall_latency_profiler_core #(
	parameter int THREAD_SLOTS = slp_pkg::THREAD_SLOTS_DEF,
	parameter int NUM_CALLS    = slp_pkg::NUM_CALLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [21:0] thread_num,
	input  logic [21:0] group_num,
	input  logic [9:0]  call_number,
	input  logic [63:0] time_ns,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [8:0]  call_index,
	output logic [63:0] elapsed_ns,
	output logic [63:0] call_count,
	output logic [63:0] orphan_count,
	output logic [63:0] busy_sum
);
	import slp_pkg::*;
	`include "syscall_latency_profiler_core_assert.svh"

	localparam int CW = (NUM_CALLS > 1) ? $clog2(NUM_CALLS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOOK = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_RES  = 3'd4;
	localparam logic [2:0] S_CLR  = 3'd5;

	logic [2:0]  state_q;
	logic [22:0] filter_q;
	logic [CW-1:0] clr_cnt_q;

	logic [1:0]  func_q;
	logic [21:0] thr_q;
	logic [21:0] grp_q;
	logic [9:0]  call_q;
	logic [63:0] time_q;

	logic          upd_en_q;
	logic          upd_orph_q;
	logic [CW-1:0] upd_addr_q;
	logic [CW-1:0] rep_addr_q;
	logic          rep_ok_q;
	logic [2:0]    stat_q;
	logic [63:0]   elap_q;

	stat_t mem_q [NUM_CALLS];
	stat_t rdata_q;
	stat_t wdata;
	logic          we, re;
	logic [CW-1:0] waddr, raddr;

	logic          out_v_q;
	logic [2:0]    o_stat_q;
	logic [8:0]    o_idx_q;
	logic [63:0]   o_elap_q, o_cnt_q, o_orph_q, o_busy_q;

	cell_ctl_t                 ctl;
	logic [THREAD_SLOTS:0]     chain;
	logic [THREAD_SLOTS-1:0]   match_v;
	logic [CW-1:0]             call_v  [THREAD_SLOTS];
	logic [63:0]               start_v [THREAD_SLOTS];
	logic                      hit, full;
	logic [CW-1:0]             hit_call;
	logic [63:0]               hit_start;
	logic                      pass, call_ok;
	logic [63:0]               elapsed;
	logic                      accept, cfg_wr;
	logic [9:0]                idx_ext;

	assign pready = 1'b1;
	assign prdata = {{9{filter_q[22]}}, filter_q};
	assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= '1;
		end else if (cfg_wr) begin
			filter_q <= pwdata[22:0];
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			thr_q  <= thread_num;
			grp_q  <= group_num;
			call_q <= call_number;
			time_q <= time_ns;
		end
	end

	// cell row
	assign chain[0] = 1'b0;
	for (genvar i = 0; i < THREAD_SLOTS; i++) begin : g_cell
		slp_cell #(.CW(CW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.key      (thr_q),
			.call_in  (call_q[CW-1:0]),
			.time_in  (time_q),
			.taken_in (chain[i]),
			.taken_out(chain[i+1]),
			.match    (match_v[i]),
			.call_o   (call_v[i]),
			.start_o  (start_v[i])
		);
	end

	always_comb begin
		hit_call  = '0;
		hit_start = '0;
		for (int i = 0; i < THREAD_SLOTS; i++) begin
			hit_call  = hit_call | call_v[i];
			hit_start = hit_start | start_v[i];
		end
	end

	assign hit     = |match_v;
	assign full    = !chain[THREAD_SLOTS];
	assign pass    = (filter_q == '1) || (!filter_q[22] && (filter_q[21:0] == grp_q));
	assign call_ok = {1'b0, call_q} < 11'(NUM_CALLS);
	assign elapsed = time_q - hit_start;

	always_comb begin
		ctl = '0;
		if (state_q == S_LOOK && func_q == FUNC_ENTER && pass && call_ok) begin
			ctl.wr_hit  = hit;
			ctl.wr_free = !hit;
		end else if (state_q == S_LOOK && func_q == FUNC_EXIT && pass) begin
			ctl.clr_hit = 1'b1;
		end
	end

	// counter memory
	always_comb begin
		wdata = rdata_q;
		if (upd_orph_q) begin
			wdata.orph = rdata_q.orph + 64'd1;
		end else begin
			wdata.cnt  = rdata_q.cnt + 64'd1;
			wdata.busy = rdata_q.busy + elap_q;
		end
		if (state_q == S_CLR) begin
			wdata = '0;
		end
	end

	assign we    = (state_q == S_CLR) || (state_q == S_UPD && upd_en_q);
	assign waddr = (state_q == S_CLR) ? clr_cnt_q : upd_addr_q;
	assign re    = (state_q == S_LOOK) || (state_q == S_RD);
	assign raddr = (state_q == S_LOOK) ? hit_call : rep_addr_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// decision registers
	always_ff @(posedge clk) begin
		if (state_q == S_LOOK) begin
			upd_en_q   <= 1'b0;
			upd_orph_q <= 1'b0;
			upd_addr_q <= hit_call;
			rep_addr_q <= call_q[CW-1:0];
			rep_ok_q   <= 1'b0;
			stat_q     <= ST_DONE;
			elap_q     <= '0;
			unique case (func_q)
				FUNC_ENTER: begin
					priority if (!pass) begin
						stat_q <= ST_FILTERED;
					end else if (!call_ok) begin
						stat_q <= ST_BADCALL;
					end else if (hit) begin
						upd_en_q   <= 1'b1;
						upd_orph_q <= 1'b1;
						rep_ok_q   <= 1'b1;
					end else if (full) begin
						stat_q <= ST_FULL;
					end else begin
						rep_ok_q <= 1'b1;
					end
				end
				FUNC_EXIT: begin
					priority if (!pass) begin
						stat_q <= ST_FILTERED;
					end else if (!hit) begin
						stat_q <= ST_NOENTRY;
					end else begin
						upd_en_q   <= 1'b1;
						rep_ok_q   <= 1'b1;
						rep_addr_q <= hit_call;
						elap_q     <= elapsed;
					end
				end
				FUNC_READ: begin
					if (!call_ok) begin
						stat_q <= ST_BADCALL;
					end else begin
						rep_ok_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign idx_ext = 10'(rep_addr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_cnt_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (state_q == S_RES && (!out_v_q || !out_stall)) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == CW'(NUM_CALLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: state_q <= S_UPD;
				S_UPD:  state_q <= S_RD;
				S_RD:   state_q <= S_RES;
				S_RES: begin
					if (!out_v_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RES && (!out_v_q || !out_stall)) begin
			o_stat_q <= stat_q;
			o_idx_q  <= rep_ok_q ? idx_ext[8:0] : '0;
			o_elap_q <= rep_ok_q ? elap_q : '0;
			o_cnt_q  <= rep_ok_q ? rdata_q.cnt : '0;
			o_orph_q <= rep_ok_q ? rdata_q.orph : '0;
			o_busy_q <= rep_ok_q ? rdata_q.busy : '0;
		end
	end

	assign out_valid    = out_v_q;
	assign status       = o_stat_q;
	assign call_index   = o_idx_q;
	assign elapsed_ns   = o_elap_q;
	assign call_count   = o_cnt_q;
	assign orphan_count = o_orph_q;
	assign busy_sum     = o_busy_q;

	`SLP_ASSERT_NEVER(a_one_owner, clk, arst_n, !$onehot0(match_v))
	`SLP_ASSERT_IMPL(a_err_zero, clk, arst_n, out_v_q && (o_stat_q != ST_DONE), (o_cnt_q == '0) && (o_busy_q == '0) && (o_idx_q == '0))
	`SLP_ASSERT_IMPL(a_upd_ok, clk, arst_n, state_q == S_UPD && upd_en_q, rep_ok_q && stat_q == ST_DONE)

endmodule

/* test/syscall_latency_profiler_core_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Profiler result checker
// Watches the request and result channels, tracks the open-call table and
// per-call counters, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module syscall_latency_profiler_core_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [22:0] cfg_filter,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  func,
	input  logic [21:0] thread_num,
	input  logic [21:0] group_num,
	input  logic [9:0]  call_number,
	input  logic [63:0] time_ns,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [8:0]  call_index,
	input  logic [63:0] elapsed_ns,
	input  logic [63:0] call_count,
	input  logic [63:0] orphan_count,
	input  logic [63:0] busy_sum,
	output int          fail_count,
	output int          pending,
	output int          result_total
);
	import slp_pkg::*;

	localparam int SLOTS = THREAD_SLOTS_DEF;
	localparam int CALLS = NUM_CALLS_DEF;

	typedef struct {
		logic [2:0]  st;
		logic [8:0]  idx;
		logic [63:0] el;
		logic [63:0] cnt;
		logic [63:0] orph;
		logic [63:0] busy;
	} profile_t;

	logic [22:0] filter_q;
	bit          open_q [SLOTS];
	logic [21:0] open_thr [SLOTS];
	logic [8:0]  open_call [SLOTS];
	logic [63:0] open_start [SLOTS];
	logic [63:0] calls_done [CALLS];
	logic [63:0] calls_orph [CALLS];
	logic [63:0] calls_busy [CALLS];
	profile_t    profile_q[$];

	function automatic bit group_match(logic [21:0] grp);
		if (filter_q == 23'h7fffff) return 1;
		if (filter_q[22]) return 0;
		return filter_q[21:0] == grp;
	endfunction

	function automatic int slot_of(logic [21:0] thr);
		for (int i = 0; i < SLOTS; i++)
			if (open_q[i] && open_thr[i] == thr) return i;
		return -1;
	endfunction

	function automatic profile_t report_of(logic [8:0] c, logic [63:0] el);
		profile_t r;
		r.st = ST_DONE; r.idx = c; r.el = el;
		r.cnt = calls_done[c]; r.orph = calls_orph[c]; r.busy = calls_busy[c];
		return r;
	endfunction

	function automatic profile_t profile_step(logic [1:0] f, logic [21:0] thr,
			logic [21:0] grp, logic [9:0] c, logic [63:0] now);
		profile_t r;
		int s;
		r = '{ST_DONE, 0, 0, 0, 0, 0};
		case (f)
			FUNC_ENTER: begin
				if (!group_match(grp)) r.st = ST_FILTERED;
				else if (c >= CALLS) r.st = ST_BADCALL;
				else begin
					s = slot_of(thr);
					if (s >= 0) calls_orph[open_call[s]] += 1;
					else begin
						for (int i = 0; i < SLOTS && s < 0; i++)
							if (!open_q[i]) s = i;
					end
					if (s < 0) r.st = ST_FULL;
					else begin
						open_q[s] = 1; open_thr[s] = thr;
						open_call[s] = c[8:0]; open_start[s] = now;
						r = report_of(c[8:0], 0);
					end
				end
			end
			FUNC_EXIT: begin
				if (!group_match(grp)) r.st = ST_FILTERED;
				else begin
					s = slot_of(thr);
					if (s < 0) r.st = ST_NOENTRY;
					else begin
						open_q[s] = 0;
						calls_done[open_call[s]] += 1;
						calls_busy[open_call[s]] += now - open_start[s];
						r = report_of(open_call[s], now - open_start[s]);
					end
				end
			end
			FUNC_READ: begin
				if (c >= CALLS) r.st = ST_BADCALL;
				else r = report_of(c[8:0], 0);
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		profile_t e;
		if (!arst_n) begin
			filter_q <= 23'h7fffff;
			fail_count <= 0;
			result_total <= 0;
			for (int i = 0; i < SLOTS; i++) open_q[i] = 0;
			for (int i = 0; i < CALLS; i++) begin
				calls_done[i] = 0; calls_orph[i] = 0; calls_busy[i] = 0;
			end
			profile_q.delete();
		end else begin
			if (cfg_we) filter_q <= cfg_filter;
			if (in_valid && !in_stall)
				profile_q.push_back(profile_step(func, thread_num, group_num,
					call_number, time_ns));
			if (out_valid && !out_stall) begin
				result_total <= result_total + 1;
				if (profile_q.size() == 0) begin
					$error("result with no request pending");
					fail_count <= fail_count + 1;
				end else begin
					e = profile_q.pop_front();
					if ({status, call_index, elapsed_ns, call_count, orphan_count, busy_sum}
						!== {e.st, e.idx, e.el, e.cnt, e.orph, e.busy}) begin
						fail_count <= fail_count + 1;
						if (status !== e.st)
							$error("status exp %0d got %0d", e.st, status);
						if (call_index !== e.idx)
							$error("call_index exp %0d got %0d", e.idx, call_index);
						if (elapsed_ns !== e.el)
							$error("elapsed_ns exp %0h got %0h", e.el, elapsed_ns);
						if (call_count !== e.cnt)
							$error("call_count exp %0h got %0h", e.cnt, call_count);
						if (orphan_count !== e.orph)
							$error("orphan_count exp %0h got %0h", e.orph, orphan_count);
						if (busy_sum !== e.busy)
							$error("busy_sum exp %0h got %0h", e.busy, busy_sum);
					end
				end
			end
		end
	end

	assign pending = profile_q.size();

endmodule

/* test/syscall_latency_profiler_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Profiler testbench
// Drives enter/exit/read requests with random gaps and stalls, sweeps the
// group filter through its extremes, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module syscall_latency_profiler_core_test;
	import slp_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  func = 0;
	logic [21:0] thread_num = 0, group_num = 0;
	logic [9:0]  call_number = 0;
	logic [63:0] time_ns = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  status;
	logic [8:0]  call_index;
	logic [63:0] elapsed_ns, call_count, orphan_count, busy_sum;
	int          fail_count, pending, result_total;
	int          idle_cycles = 0;
	bit          hold_long = 0;
	bit          stall_on = 1;
	logic [63:0] clock_ns = 0;

	always #2 clk = ~clk;

	syscall_latency_profiler_core u_dut (.*);

	syscall_latency_profiler_core_checker u_check (
		.clk, .arst_n,
		.cfg_we(psel && penable && pwrite && pready && paddr == 3'd0),
		.cfg_filter(pwdata[22:0]),
		.in_valid, .in_stall, .func, .thread_num, .group_num, .call_number,
		.time_ns, .out_valid, .out_stall, .status, .call_index, .elapsed_ns,
		.call_count, .orphan_count, .busy_sum,
		.fail_count, .pending, .result_total
	);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result stall: mostly short random stalls, one forced long hold
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (hold_long) out_stall <= 1;
		else if (!stall_on) out_stall <= 0;
		else if (r < 25) out_stall <= 1;
		else if (r < 27) out_stall <= 1;
		else out_stall <= 0;
	end

	task automatic cfg_write(logic [22:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic send_request(logic [1:0] f, logic [21:0] thr, logic [21:0] grp,
			logic [9:0] c, logic [63:0] t, bit gaps);
		int g;
		@(posedge clk);
		if (gaps) begin
			g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
			repeat (g) @(posedge clk);
		end
		in_valid <= 1; func <= f; thread_num <= thr; group_num <= grp;
		call_number <= c; time_ns <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		in_valid <= 0;
	endtask

	task automatic random_phase(int n, logic [21:0] grp_hit, bit filtered);
		int r;
		logic [21:0] thr, grp;
		logic [9:0] c;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			thr = ($urandom_range(0, 9) == 0) ? 22'($urandom) : 22'($urandom_range(0, 79));
			grp = (filtered && $urandom_range(0, 3) == 0) ? 22'($urandom) : grp_hit;
			c = ($urandom_range(0, 19) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
			clock_ns += $urandom_range(0, 5000);
			if ($urandom_range(0, 49) == 0) clock_ns = {$urandom, $urandom};
			if (r < 45) send_request(FUNC_ENTER, thr, grp, c, clock_ns, 1);
			else if (r < 85) send_request(FUNC_EXIT, thr, grp, c, clock_ns, 1);
			else if (r < 97) send_request(FUNC_READ, thr, grp, c, clock_ns, 1);
			else send_request(2'd3, thr, grp, c, clock_ns, 1);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: extremes, reenter, exit without entry, bad call, func 3
		send_request(FUNC_READ, 0, 0, 10'd511, 0, 0);
		send_request(FUNC_READ, 0, 0, 10'd512, 0, 0);
		send_request(FUNC_READ, 0, 0, 10'h3ff, 0, 0);
		send_request(FUNC_ENTER, 22'h3fffff, 22'h3fffff, 10'd511, 64'hffff_ffff_ffff_fff0, 0);
		send_request(FUNC_EXIT, 22'h3fffff, 22'h3fffff, 0, 64'h10, 0);
		send_request(FUNC_ENTER, 0, 0, 10'd0, 64'd100, 0);
		send_request(FUNC_ENTER, 0, 0, 10'd1, 64'd200, 0);
		send_request(FUNC_EXIT, 0, 0, 10'h3ff, 64'd150, 0);
		send_request(FUNC_EXIT, 0, 0, 0, 64'd300, 0);
		send_request(FUNC_ENTER, 5, 0, 10'h3ff, 64'd1, 0);
		send_request(2'd3, 22'h3fffff, 22'h3fffff, 10'h3ff, '1, 0);
		// fill the table, then one more
		for (int i = 0; i < 65; i++)
			send_request(FUNC_ENTER, 22'(1000 + i), 0, 10'(i % 8), 64'(i), 0);
		for (int i = 0; i < 64; i++)
			send_request(FUNC_EXIT, 22'(1000 + i), 0, 0, 64'(i * 7 + 50), 0);
		drain();

		// long hold on the result side while requests keep coming
		hold_long = 1;
		fork
			random_phase(40, 22'd0, 0);
			begin repeat (300) @(posedge clk); hold_long = 0; end
		join
		drain();

		random_phase(500, 22'd0, 0);
		drain();
		cfg_write(23'd77);
		random_phase(300, 22'd77, 1);
		drain();
		cfg_write(23'h3fffff);
		random_phase(200, 22'h3fffff, 1);
		drain();
		cfg_write(23'h400000);
		random_phase(150, 22'd0, 1);
		drain();
		cfg_write(23'd0);
		random_phase(200, 22'd0, 1);
		drain();
		cfg_write(23'h7fffff);
		stall_on = 0;
		random_phase(150, 22'd0, 0);
		stall_on = 1;
		random_phase(350, 22'd0, 0);
		drain();

		$display("Covered %0d results over filter settings all, 77, max, most negative, 0.",
			result_total);
		if (fail_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
